// File: hw/rtl/pdc_pkg.sv
// shared types, codes and constants of the ph dosing controller
package pdc_pkg;

  localparam int PhWidth = 11;
  localparam int TickWidth = 16;
  localparam int CfgIndexWidth = 8;

  // command codes carried in tuser
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_ON = 2'd1;
  localparam logic [1:0] CMD_OFF = 2'd2;

  // phase codes
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_RUNNING = 3'd1;
  localparam logic [2:0] PH_ACID_ON = 3'd2;
  localparam logic [2:0] PH_ACID_WAIT = 3'd3;
  localparam logic [2:0] PH_BASE_ON = 3'd4;
  localparam logic [2:0] PH_BASE_WAIT = 3'd5;

  // event codes
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_TIMEOUT = 2'd1;
  localparam logic [1:0] EV_PH_HIGH = 2'd2;
  localparam logic [1:0] EV_PH_LOW = 2'd3;

  // configuration register indexes
  localparam logic [CfgIndexWidth-1:0] REG_UPPER = 8'd0;
  localparam logic [CfgIndexWidth-1:0] REG_LOWER = 8'd1;
  localparam logic [CfgIndexWidth-1:0] REG_DOSE = 8'd2;
  localparam logic [CfgIndexWidth-1:0] REG_WAIT = 8'd3;

  localparam logic [PhWidth-1:0] UPPER_RESET = 11'd750;
  localparam logic [PhWidth-1:0] LOWER_RESET = 11'd650;
  localparam logic [TickWidth-1:0] TICKS_RESET = 16'd1000;
  localparam logic [TickWidth-1:0] TICKS_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0]           phase;
    logic [TickWidth-1:0] elapsed;
    logic                 acid;
    logic                 base;
  } state_t;

  typedef struct packed {
    logic [PhWidth-1:0]   upper;
    logic [PhWidth-1:0]   lower;
    logic [TickWidth-1:0] dose_ticks;
    logic [TickWidth-1:0] wait_ticks;
  } cfg_t;

  // packed so that acid_pump lands in bit 0
  typedef struct packed {
    logic [1:0] event_seen;
    logic [2:0] phase;
    logic       base_pump;
    logic       acid_pump;
  } result_t;

endpackage

// File: hw/rtl/pdc_step.sv
// next-state and result logic for one request of the dosing controller
module pdc_step import pdc_pkg::*; (
  input  state_t             st,
  input  cfg_t               cfg,
  input  logic [1:0]         cmd,
  input  logic [PhWidth-1:0] sample,
  output state_t             st_next,
  output result_t            res
);

  logic [TickWidth-1:0] elapsed_inc;
  logic                 expired;
  logic [1:0]           ev;

  always_comb begin
    elapsed_inc = (st.elapsed != TICKS_MAX) ? st.elapsed + 16'd1 : st.elapsed;
    case (st.phase)
      PH_ACID_ON, PH_BASE_ON: expired = (elapsed_inc >= cfg.dose_ticks);
      PH_ACID_WAIT, PH_BASE_WAIT: expired = (elapsed_inc >= cfg.wait_ticks);
      default: expired = 1'b0;
    endcase
    if (expired) begin
      ev = EV_TIMEOUT;
    end else if (sample > cfg.upper) begin
      ev = EV_PH_HIGH;
    end else if (sample < cfg.lower) begin
      ev = EV_PH_LOW;
    end else begin
      ev = EV_NONE;
    end
  end

  always_comb begin
    st_next = st;
    res.event_seen = EV_NONE;
    case (cmd)
      CMD_TICK: begin
        if (st.phase != PH_IDLE) begin
          res.event_seen = ev;
          st_next.elapsed = elapsed_inc;
          case (st.phase)
            PH_RUNNING: begin
              if (ev == EV_PH_HIGH) begin
                st_next.phase = PH_ACID_ON;
                st_next.elapsed = '0;
                st_next.acid = 1'b1;
              end else if (ev == EV_PH_LOW) begin
                st_next.phase = PH_BASE_ON;
                st_next.elapsed = '0;
                st_next.base = 1'b1;
              end
            end
            PH_ACID_ON: begin
              if (ev == EV_TIMEOUT) begin
                st_next.phase = PH_ACID_WAIT;
                st_next.elapsed = '0;
                st_next.acid = 1'b0;
              end
            end
            PH_BASE_ON: begin
              if (ev == EV_TIMEOUT) begin
                st_next.phase = PH_BASE_WAIT;
                st_next.elapsed = '0;
                st_next.base = 1'b0;
              end
            end
            PH_ACID_WAIT, PH_BASE_WAIT: begin
              if (ev == EV_TIMEOUT) begin
                st_next.phase = PH_RUNNING;
                st_next.elapsed = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      CMD_ON: begin
        if (st.phase == PH_IDLE) begin
          st_next.phase = PH_RUNNING;
          st_next.elapsed = '0;
        end
      end
      CMD_OFF: begin
        st_next.phase = PH_IDLE;
        st_next.elapsed = '0;
        st_next.acid = 1'b0;
        st_next.base = 1'b0;
      end
      default: begin
      end
    endcase
    res.acid_pump = st_next.acid;
    res.base_pump = st_next.base;
    res.phase = st_next.phase;
  end

endmodule

// File: hw/rtl/ph_dosing_controller_core.sv
// top level of the on/off ph dosing controller with dosing and wait timers
// One request (a 1 ms tick with a pH sample, control on or control off) is taken
// every clock cycle while the result side keeps up. A request is held in the
// input register, then the phase machine updates and the result register loads, and
// the result appears on the result port; a stalled result holds the request there.
// The rate is set by the combinational phase and tick-counter update in pdc_step.
// Configuration writes are accepted in any cycle and must only be made while no
// request is in flight.
module ph_dosing_controller_core import pdc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [15:0]              s_axis_tdata,  // [10:0] ph_sample, rest zero
  input  logic [1:0]               s_axis_tuser,  // [1:0] cmd
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [0] acid_pump, [1] base_pump, [4:2] phase, [6:5] event_seen, [7] zero
  output logic [7:0]               m_axis_tdata,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [15:0]              cfg_data
);

  cfg_t               cfg;
  state_t             st;
  state_t             st_next;
  result_t            res_next;
  result_t            res;
  logic               in_valid;
  logic [1:0]         in_cmd;
  logic [PhWidth-1:0] in_sample;
  logic               adv;

  assign cfg_ready = 1'b1;
  assign adv = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || adv;
  assign m_axis_tdata = {1'b0, res};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.upper <= UPPER_RESET;
      cfg.lower <= LOWER_RESET;
      cfg.dose_ticks <= TICKS_RESET;
      cfg.wait_ticks <= TICKS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_UPPER: cfg.upper <= cfg_data[PhWidth-1:0];
        REG_LOWER: cfg.lower <= cfg_data[PhWidth-1:0];
        REG_DOSE: cfg.dose_ticks <= cfg_data;
        REG_WAIT: cfg.wait_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd <= s_axis_tuser;
      in_sample <= s_axis_tdata[PhWidth-1:0];
    end
  end

  pdc_step u_step (
    .st      (st),
    .cfg     (cfg),
    .cmd     (in_cmd),
    .sample  (in_sample),
    .st_next (st_next),
    .res     (res_next)
  );

  // state and result register advance together
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase <= PH_IDLE;
      st.elapsed <= '0;
      st.acid <= 1'b0;
      st.base <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (adv) begin
        st <= st_next;
      end
      if (adv) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_next;
    end
  end

endmodule

// File: hw/rtl/pdc_checker.sv
// port-level checks of the dosing controller results, bound to the top level
module pdc_checker import pdc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_acid_phase: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[4:2] == PH_ACID_ON)))
    else $error("acid pump disagrees with phase");

  a_base_phase: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[1] == (m_axis_tdata[4:2] == PH_BASE_ON)))
    else $error("base pump disagrees with phase");

  a_event_active: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[6:5] != EV_NONE) |-> (m_axis_tdata[4:2] != PH_IDLE))
    else $error("event reported while idle");

endmodule

bind ph_dosing_controller_core pdc_checker u_pdc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
